### rtl/core/rgbhsv_pkg.sv
package rgbhsv_pkg;

    localparam int CH_W                  = 8;
    localparam int HUE_W                 = 15;
    localparam int HUE_FRACTION_BITS_DEF = 6;
    // 60 * diff needs 6 more bits than one channel
    localparam int HUE_NUM_W             = CH_W + 6;
    // 255 * delta
    localparam int SAT_DVD_W             = 2 * CH_W;

    typedef logic [1:0] sector_t;

    localparam sector_t SECTOR_RED   = 2'd0;
    localparam sector_t SECTOR_GREEN = 2'd1;
    localparam sector_t SECTOR_BLUE  = 2'd2;

    typedef struct packed {
        logic    gray;
        logic    neg;
        sector_t sector;
    } hue_meta_t;

endpackage

### rtl/core/rgbhsv_front.sv
module rgbhsv_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [rgbhsv_pkg::CH_W-1:0]        red,
    input  logic [rgbhsv_pkg::CH_W-1:0]        green,
    input  logic [rgbhsv_pkg::CH_W-1:0]        blue,
    output logic                               out_valid,
    output logic [rgbhsv_pkg::CH_W-1:0]        bright,
    output logic [rgbhsv_pkg::CH_W-1:0]        delta,
    output logic [rgbhsv_pkg::SAT_DVD_W-1:0]   sat_dvd,
    output logic [rgbhsv_pkg::HUE_NUM_W-1:0]   hue_num,
    output rgbhsv_pkg::hue_meta_t              meta
);

    localparam int CW = rgbhsv_pkg::CH_W;

    logic [CW-1:0]         mx_next, mn_next;
    logic [CW-1:0]         delta_next;
    logic [CW:0]           diff_next;
    logic [CW-1:0]         absd_next;
    rgbhsv_pkg::hue_meta_t meta_next;

    logic                  v1_reg;
    logic [CW-1:0]         mx_reg, delta_reg, absd_reg;
    rgbhsv_pkg::hue_meta_t meta1_reg;

    logic                              v2_reg;
    logic [CW-1:0]                     mx2_reg, delta2_reg;
    logic [rgbhsv_pkg::SAT_DVD_W-1:0]  sat_dvd_reg;
    logic [rgbhsv_pkg::HUE_NUM_W-1:0]  hue_num_reg;
    rgbhsv_pkg::hue_meta_t             meta2_reg;

    always_comb
    begin
        mx_next = red;
        if (green > mx_next) mx_next = green;
        if (blue > mx_next) mx_next = blue;
        mn_next = red;
        if (green < mn_next) mn_next = green;
        if (blue < mn_next) mn_next = blue;
        delta_next = mx_next - mn_next;

        // red wins ties, then green
        if (red == mx_next)
        begin
            meta_next.sector = rgbhsv_pkg::SECTOR_RED;
            diff_next = {1'b0, green} - {1'b0, blue};
        end
        else if (green == mx_next)
        begin
            meta_next.sector = rgbhsv_pkg::SECTOR_GREEN;
            diff_next = {1'b0, blue} - {1'b0, red};
        end
        else
        begin
            meta_next.sector = rgbhsv_pkg::SECTOR_BLUE;
            diff_next = {1'b0, red} - {1'b0, green};
        end
        meta_next.neg  = diff_next[CW];
        meta_next.gray = (delta_next == '0);
        absd_next = diff_next[CW] ? CW'(-diff_next) : diff_next[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg     <= mx_next;
        delta_reg  <= delta_next;
        absd_reg   <= absd_next;
        meta1_reg  <= meta_next;

        mx2_reg    <= mx_reg;
        delta2_reg <= delta_reg;
        meta2_reg  <= meta1_reg;
        // 255*delta and 60*|diff| as shift and subtract
        sat_dvd_reg <= {delta_reg, {CW{1'b0}}} - rgbhsv_pkg::SAT_DVD_W'(delta_reg);
        hue_num_reg <= {absd_reg, 6'd0} - {4'd0, absd_reg, 2'd0};
    end

    assign out_valid = v2_reg;
    assign bright    = mx2_reg;
    assign delta     = delta2_reg;
    assign sat_dvd   = sat_dvd_reg;
    assign hue_num   = hue_num_reg;
    assign meta      = meta2_reg;

endmodule

### rtl/core/rgbhsv_div.sv
module rgbhsv_div
#(
    parameter int QUOT_W    = 8,
    parameter int DIVISOR_W = 8,
    parameter int TAG_W     = 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [QUOT_W+DIVISOR_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]          divisor,
    input  logic [TAG_W-1:0]              in_tag,
    output logic                          out_valid,
    output logic [QUOT_W-1:0]             quotient,
    output logic [TAG_W-1:0]              out_tag
);

    // One quotient bit per stage. The top DIVISOR_W bits of the dividend must
    // already be below the divisor, so QUOT_W steps give the whole quotient.
    localparam int EXT_W = QUOT_W + DIVISOR_W;

    logic                 valid_reg [QUOT_W];
    logic [DIVISOR_W-1:0] rem_reg   [QUOT_W];
    logic [DIVISOR_W-1:0] dvs_reg   [QUOT_W];
    logic [QUOT_W-1:0]    low_reg   [QUOT_W];
    logic [QUOT_W-1:0]    quo_reg   [QUOT_W];
    logic [TAG_W-1:0]     tag_reg   [QUOT_W];

    for (genvar i = 0; i < QUOT_W; i++)
    begin : g_step
        logic                 v_in;
        logic [DIVISOR_W-1:0] rem_in, dvs_in;
        logic [QUOT_W-1:0]    low_in, quo_in;
        logic [TAG_W-1:0]     tag_in;
        logic [DIVISOR_W:0]   trial;
        logic                 ge;
        logic [DIVISOR_W-1:0] rem_next;

        if (i == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = dividend[EXT_W-1 -: DIVISOR_W];
            assign low_in = dividend[QUOT_W-1:0];
            assign quo_in = '0;
            assign dvs_in = divisor;
            assign tag_in = in_tag;
        end
        else
        begin : g_rest
            assign v_in   = valid_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
            assign tag_in = tag_reg[i-1];
        end

        always_comb
        begin
            trial    = {rem_in, low_in[QUOT_W-1]};
            ge       = (trial >= {1'b0, dvs_in});
            rem_next = ge ? DIVISOR_W'(trial - {1'b0, dvs_in}) : trial[DIVISOR_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= rem_next;
            low_reg[i] <= {low_in[QUOT_W-2:0], 1'b0};
            quo_reg[i] <= {quo_in[QUOT_W-2:0], ge};
            dvs_reg[i] <= dvs_in;
            tag_reg[i] <= tag_in;
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign quotient  = quo_reg[QUOT_W-1];
    assign out_tag   = tag_reg[QUOT_W-1];

endmodule

### rtl/core/rgbhsv_back.sv
module rgbhsv_back
#(
    parameter int HUE_FRACTION_BITS = rgbhsv_pkg::HUE_FRACTION_BITS_DEF,
    parameter int QUOT_W            = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [QUOT_W-1:0]             hue_q,
    input  logic [QUOT_W-1:0]             sat_q,
    input  rgbhsv_pkg::hue_meta_t         meta,
    input  logic [rgbhsv_pkg::CH_W-1:0]   bright_in,
    output logic                          done,
    output logic [rgbhsv_pkg::HUE_W-1:0]  hue,
    output logic [rgbhsv_pkg::CH_W-1:0]   saturation,
    output logic [rgbhsv_pkg::CH_W-1:0]   brightness
);

    localparam int HUE_SIXTH  = 60 << HUE_FRACTION_BITS;
    localparam int HUE_CIRCLE = 6 * HUE_SIXTH;
    localparam int FULL_W     = $clog2(HUE_CIRCLE);

    logic [FULL_W-1:0]             base, q_ext, hue_full;
    logic                          done_reg;
    logic [rgbhsv_pkg::HUE_W-1:0]  hue_reg;
    logic [rgbhsv_pkg::CH_W-1:0]   sat_reg, bright_reg;

    always_comb
    begin
        case (meta.sector)
            rgbhsv_pkg::SECTOR_RED:   base = '0;
            rgbhsv_pkg::SECTOR_GREEN: base = FULL_W'(2 * HUE_SIXTH);
            default:                  base = FULL_W'(4 * HUE_SIXTH);
        endcase
        q_ext = FULL_W'(hue_q);
        if (meta.gray)
            hue_full = '0;
        else if (!meta.neg)
            hue_full = base + q_ext;
        else if ((meta.sector == rgbhsv_pkg::SECTOR_RED) && (q_ext != '0))
            hue_full = FULL_W'(HUE_CIRCLE) - q_ext;   // wrap below zero
        else
            hue_full = base - q_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg    <= rgbhsv_pkg::HUE_W'(hue_full);
        sat_reg    <= meta.gray ? '0 : sat_q[rgbhsv_pkg::CH_W-1:0];
        bright_reg <= bright_in;
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

### rtl/core/rgb_to_hsv_converter.sv
// RGB to HSV converter, fully pipelined.
//
// Input: drive red, green and blue with start high; a pixel word is taken
// at every clock edge where start is high and busy is low. busy is always
// low, so a new pixel may enter every cycle.
// Output: done is high for exactly one cycle with hue, saturation and
// brightness of one pixel; results leave in input order. The receiver
// cannot stall, so it must take each word in the cycle done is high.
// Hue is in units of 1/2^HUE_FRACTION_BITS degree, masked to 15 bits.
// Two front stages find max, min and the dividends, each divider
// pipeline resolves one quotient bit per stage, and one stage assembles
// the hue. Throughput is one pixel per cycle.
// Reset clears all valid bits in flight; no result appears after reset
// until a pixel is taken.
module rgb_to_hsv_converter
#(
    parameter int HUE_FRACTION_BITS = rgbhsv_pkg::HUE_FRACTION_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rgbhsv_pkg::CH_W-1:0]   red,
    input  logic [rgbhsv_pkg::CH_W-1:0]   green,
    input  logic [rgbhsv_pkg::CH_W-1:0]   blue,
    output logic                          done,
    output logic [rgbhsv_pkg::HUE_W-1:0]  hue,
    output logic [rgbhsv_pkg::CH_W-1:0]   saturation,
    output logic [rgbhsv_pkg::CH_W-1:0]   brightness
);

    localparam int CW         = rgbhsv_pkg::CH_W;
    localparam int HUE_Q_W    = 6 + HUE_FRACTION_BITS;
    localparam int DIV_STAGES = (HUE_Q_W > CW) ? HUE_Q_W : CW;
    localparam int EXT_W      = DIV_STAGES + CW;
    localparam int META_W     = $bits(rgbhsv_pkg::hue_meta_t);
    localparam int LATENCY    = 3 + DIV_STAGES;
    localparam int HUE_CIRCLE = 360 << HUE_FRACTION_BITS;

    logic                              fr_valid;
    logic [CW-1:0]                     fr_bright, fr_delta;
    logic [rgbhsv_pkg::SAT_DVD_W-1:0]  fr_sat_dvd;
    logic [rgbhsv_pkg::HUE_NUM_W-1:0]  fr_hue_num;
    rgbhsv_pkg::hue_meta_t             fr_meta;

    logic [EXT_W-1:0]       sat_dvd_ext, hue_dvd_ext;
    logic                   hdiv_valid, sdiv_valid;
    logic [DIV_STAGES-1:0]  hdiv_q, sdiv_q;
    logic [META_W-1:0]      hdiv_tag;
    logic [CW-1:0]          sdiv_tag;
    rgbhsv_pkg::hue_meta_t  bk_meta;

    // pipeline never holds off a word
    assign busy = 1'b0;

    rgbhsv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (fr_valid),
        .bright    (fr_bright),
        .delta     (fr_delta),
        .sat_dvd   (fr_sat_dvd),
        .hue_num   (fr_hue_num),
        .meta      (fr_meta)
    );

    assign sat_dvd_ext = EXT_W'(fr_sat_dvd);
    assign hue_dvd_ext = EXT_W'(fr_hue_num) << HUE_FRACTION_BITS;

    rgbhsv_div
    #(
        .QUOT_W    (DIV_STAGES),
        .DIVISOR_W (CW),
        .TAG_W     (META_W)
    )
    u_hue_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .dividend  (hue_dvd_ext),
        .divisor   (fr_delta),
        .in_tag    (fr_meta),
        .out_valid (hdiv_valid),
        .quotient  (hdiv_q),
        .out_tag   (hdiv_tag)
    );

    rgbhsv_div
    #(
        .QUOT_W    (DIV_STAGES),
        .DIVISOR_W (CW),
        .TAG_W     (CW)
    )
    u_sat_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .dividend  (sat_dvd_ext),
        .divisor   (fr_bright),
        .in_tag    (fr_bright),
        .out_valid (sdiv_valid),
        .quotient  (sdiv_q),
        .out_tag   (sdiv_tag)
    );

    assign bk_meta = rgbhsv_pkg::hue_meta_t'(hdiv_tag);

    rgbhsv_back
    #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .QUOT_W            (DIV_STAGES)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hdiv_valid && sdiv_valid),
        .hue_q      (hdiv_q),
        .sat_q      (sdiv_q),
        .meta       (bk_meta),
        .bright_in  (sdiv_tag),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

`ifndef SYNTHESIS
    a_div_lockstep : assert property (@(posedge clk) disable iff (!rst_n)
        hdiv_valid == sdiv_valid)
        else $error("hue and saturation dividers out of step");

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result word missing at expected latency");

    a_gray_hue : assert property (@(posedge clk) disable iff (!rst_n)
        done && (saturation == '0) |-> (hue == '0))
        else $error("zero saturation with nonzero hue");

    a_black : assert property (@(posedge clk) disable iff (!rst_n)
        done && (brightness == '0) |-> (saturation == '0))
        else $error("black pixel with nonzero saturation");

    a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
        done && (HUE_CIRCLE < (1 << rgbhsv_pkg::HUE_W))
        |-> (32'(hue) < HUE_CIRCLE))
        else $error("hue beyond full circle");
`endif

endmodule
